// ===== design/ckx_pkg.sv =====
`default_nettype none

package ckx_pkg;

    localparam int KMER_LEN_W   = 6;
    localparam int KMER_MAX     = 32;
    localparam int WORD_W       = 2 * KMER_MAX;
    localparam int COUNT_W      = 32;
    localparam int RUN_W        = 6;

    localparam logic [KMER_LEN_W-1:0] KMER_LEN_RESET = 6'd31;
    localparam logic [KMER_LEN_W-1:0] KMER_LEN_MAX   = 6'd32;
    localparam logic [RUN_W-1:0]      RUN_SAT        = 6'd63;
    localparam logic [COUNT_W-1:0]    COUNT_SAT      = 32'hFFFF_FFFF;

    // ASCII codes of the four bases, both cases.
    localparam logic [7:0] CHAR_A_UP = 8'h41;
    localparam logic [7:0] CHAR_C_UP = 8'h43;
    localparam logic [7:0] CHAR_G_UP = 8'h47;
    localparam logic [7:0] CHAR_T_UP = 8'h54;
    localparam logic [7:0] CHAR_A_LO = 8'h61;
    localparam logic [7:0] CHAR_C_LO = 8'h63;
    localparam logic [7:0] CHAR_G_LO = 8'h67;
    localparam logic [7:0] CHAR_T_LO = 8'h74;

    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;
    localparam logic [1:0] COMP_XOR = 2'd3;

    typedef struct packed {
        logic [7:0] base_char;
        logic       last_base;
    } item_t;

    typedef struct packed {
        logic               kmer_valid;
        logic [WORD_W-1:0]  kmer_value;
        logic [COUNT_W-1:0] emitted_count;
        logic               sequence_end;
    } result_t;

    // Snapshot of one item after the rolling update, handed to the compare stage.
    typedef struct packed {
        logic               emit;
        logic [WORD_W-1:0]  fwd;
        logic [WORD_W-1:0]  rev;
        logic [COUNT_W-1:0] total;
        logic               last;
    } roll_t;

    typedef struct packed {
        logic       ok;
        logic [1:0] code;
    } base_code_t;

    function automatic base_code_t base_code(input logic [7:0] ch);
        base_code_t r;
        r.ok = 1'b1;
        case (ch)
            CHAR_A_UP, CHAR_A_LO: r.code = CODE_A;
            CHAR_C_UP, CHAR_C_LO: r.code = CODE_C;
            CHAR_G_UP, CHAR_G_LO: r.code = CODE_G;
            CHAR_T_UP, CHAR_T_LO: r.code = CODE_T;
            default:
            begin
                r.ok   = 1'b0;
                r.code = CODE_A;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/ckx_roll.sv =====
`default_nettype none

module ckx_roll
    import ckx_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire logic [KMER_LEN_W-1:0] kmer_length,
    input  wire item_t                 item,
    output roll_t                      snap
);

    logic [WORD_W-1:0]  fwd_reg, fwd_next;
    logic [WORD_W-1:0]  rev_reg, rev_next;
    logic [RUN_W-1:0]   run_reg, run_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    roll_t              snap_reg, snap_next;

    logic [KMER_LEN_W-1:0] k_eff;
    logic [WORD_W-1:0]     mask;
    logic [WORD_W-1:0]     ins_word;
    base_code_t            bc;

    always_comb
    begin
        if (kmer_length == '0)
            k_eff = KMER_LEN_W'(1);
        else if (kmer_length > KMER_LEN_MAX)
            k_eff = KMER_LEN_MAX;
        else
            k_eff = kmer_length;
    end

    // Mask covers the low k bases; the complement of the new base enters at base k-1.
    always_comb
    begin
        bc = base_code(item.base_char);
        for (int i = 0; i < KMER_MAX; i++)
        begin
            mask[2*i +: 2]     = (KMER_LEN_W'(i) < k_eff) ? 2'b11 : 2'b00;
            ins_word[2*i +: 2] = (KMER_LEN_W'(i) == k_eff - KMER_LEN_W'(1))
                                 ? (bc.code ^ COMP_XOR) : 2'b00;
        end
    end

    always_comb
    begin
        fwd_next   = '0;
        rev_next   = '0;
        run_next   = '0;
        total_next = total_reg;
        snap_next.emit = 1'b0;
        if (bc.ok)
        begin
            fwd_next = ((fwd_reg << 2) & mask) | WORD_W'(bc.code);
            rev_next = ((rev_reg >> 2) & mask) | ins_word;
            run_next = (run_reg < RUN_SAT) ? run_reg + RUN_W'(1) : run_reg;
            if (run_next >= k_eff)
            begin
                snap_next.emit = 1'b1;
                if (total_reg < COUNT_SAT)
                    total_next = total_reg + COUNT_W'(1);
            end
        end
        snap_next.fwd   = fwd_next;
        snap_next.rev   = rev_next;
        snap_next.total = total_next;
        snap_next.last  = item.last_base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg   <= '0;
            rev_reg   <= '0;
            run_reg   <= '0;
            total_reg <= '0;
        end
        else if (load)
        begin
            if (item.last_base)
            begin
                fwd_reg   <= '0;
                rev_reg   <= '0;
                run_reg   <= '0;
                total_reg <= '0;
            end
            else
            begin
                fwd_reg   <= fwd_next;
                rev_reg   <= rev_next;
                run_reg   <= run_next;
                total_reg <= total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            snap_reg <= snap_next;
    end

    assign snap = snap_reg;

endmodule

`default_nettype wire

// ===== design/ckx_canon.sv =====
`default_nettype none

module ckx_canon
    import ckx_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  load,
    input  wire roll_t snap,
    output result_t    result
);

    result_t result_reg, result_next;

    always_comb
    begin
        result_next.kmer_valid    = snap.emit;
        result_next.emitted_count = snap.total;
        result_next.sequence_end  = snap.last;
        if (!snap.emit)
            result_next.kmer_value = '0;
        else if (snap.fwd > snap.rev)
            result_next.kmer_value = snap.fwd;
        else
            result_next.kmer_value = snap.rev;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ===== design/canonical_kmer_extractor.sv =====
// Canonical k-mer extractor. Each input beat carries one ASCII character
// and a last flag; every input beat produces exactly one result beat. The
// block sustains one beat per clock cycle while the output is not stalled.
// The rolling forward and reverse-complement words update as the character
// is accepted and are registered in the snapshot stage; the larger of the
// two is then picked and registered in the output register once that
// register is free. Updating the rolling words as each character is
// accepted is what lets a character follow in every cycle. The
// k-mer length register may be written only while no beat is in flight.
`default_nettype none

module canonical_kmer_extractor
    import ckx_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  item_valid,
    output      logic                  item_stall,
    input  wire item_t                 item_data,

    output      logic                  result_valid,
    input  wire logic                  result_stall,
    output      result_t               result_data,

    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire logic [KMER_LEN_W-1:0] cfg_data
);

    logic [KMER_LEN_W-1:0] kmer_length_reg;
    logic                  snap_valid_reg;
    logic                  result_valid_reg;
    logic                  item_accept;
    logic                  out_free;
    logic                  snap_move;
    roll_t                 snap;

    // The register port never pushes back.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            kmer_length_reg <= KMER_LEN_RESET;
        else if (cfg_valid && cfg_ready)
            kmer_length_reg <= cfg_data;
    end

    // The output register is free when it is empty or its beat leaves now.
    // The snapshot stage moves forward whenever it holds a beat and the
    // output register is free, so a new character can enter in the same cycle.
    assign out_free    = !result_valid_reg || !result_stall;
    assign snap_move   = snap_valid_reg && out_free;
    assign item_stall  = snap_valid_reg && !out_free;
    assign item_accept = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_accept)
                snap_valid_reg <= 1'b1;
            else if (snap_move)
                snap_valid_reg <= 1'b0;

            if (snap_move)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    ckx_roll u_roll (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (item_accept),
        .kmer_length (kmer_length_reg),
        .item        (item_data),
        .snap        (snap)
    );

    ckx_canon u_canon (
        .clk    (clk),
        .load   (snap_move),
        .snap   (snap),
        .result (result_data)
    );

    assign result_valid = result_valid_reg;

    // A result without a k-mer always carries a zero value.
    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_data.kmer_valid |-> result_data.kmer_value == '0)
        else $error("k-mer value not zero on a beat without a k-mer");

    // An emitted k-mer is always counted.
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.kmer_valid |-> result_data.emitted_count != '0)
        else $error("emitted count is zero on a beat with a k-mer");

    // A beat waiting behind a stalled output is kept, not dropped.
    a_snap_held: assert property (@(posedge clk) disable iff (!rst_n)
        snap_valid_reg && result_valid && result_stall |=> snap_valid_reg)
        else $error("pending beat lost while output stalled");

    // The input side only stalls when the internal stage is full.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> snap_valid_reg && result_valid && result_stall)
        else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire

// ===== sim/canonical_kmer_extractor_tb.sv =====
`timescale 1ns / 1ps

module canonical_kmer_extractor_tb
    import ckx_pkg::*;
();

    // Scoreboard: rolls its own forward and reverse-complement words for
    // every accepted character and holds the result beats still due from the
    // block, oldest first.
    class kmer_scoreboard;

        logic [KMER_LEN_W-1:0] kmer_len;
        logic [WORD_W-1:0]     fwd_word;
        logic [WORD_W-1:0]     rc_word;
        int unsigned           run_len;
        logic [COUNT_W-1:0]    seq_total;
        result_t               results_due[$];
        int unsigned           mismatches;

        function new();
            kmer_len   = KMER_LEN_RESET;
            fwd_word   = '0;
            rc_word    = '0;
            run_len    = 0;
            seq_total  = '0;
            mismatches = 0;
        endfunction

        function void set_kmer_length(logic [KMER_LEN_W-1:0] value);
            kmer_len = value;
        endfunction

        // Notes one accepted character and queues the result beat it causes.
        function void take_char(item_t it);
            int unsigned          k;
            logic [WORD_W-1:0]    mask;
            logic                 is_base;
            logic [1:0]           code;
            result_t              r;
            // A length of zero acts as one, anything above the maximum as the maximum.
            if (kmer_len == 0)
                k = 1;
            else if (kmer_len > KMER_LEN_MAX)
                k = KMER_MAX;
            else
                k = {26'd0, kmer_len};
            mask = (k == KMER_MAX) ? {WORD_W{1'b1}} : ((64'd1 << (2 * k)) - 64'd1);
            is_base = 1'b1;
            code    = CODE_A;
            case (it.base_char)
                CHAR_A_UP, CHAR_A_LO: code = CODE_A;
                CHAR_C_UP, CHAR_C_LO: code = CODE_C;
                CHAR_G_UP, CHAR_G_LO: code = CODE_G;
                CHAR_T_UP, CHAR_T_LO: code = CODE_T;
                default:              is_base = 1'b0;
            endcase
            r = '0;
            if (!is_base)
            begin
                // Anything but a base breaks the run; the sequence total is kept.
                fwd_word = '0;
                rc_word  = '0;
                run_len  = 0;
            end
            else
            begin
                fwd_word = ((fwd_word << 2) & mask) | {62'd0, code};
                rc_word  = ((rc_word >> 2) & mask)
                         | ({62'd0, code ^ COMP_XOR} << (2 * (k - 1)));
                if (run_len < RUN_SAT)
                    run_len++;
                if (run_len >= k)
                begin
                    r.kmer_valid = 1'b1;
                    r.kmer_value = (fwd_word > rc_word) ? fwd_word : rc_word;
                    if (seq_total != COUNT_SAT)
                        seq_total++;
                end
            end
            r.emitted_count = seq_total;
            r.sequence_end  = it.last_base;
            results_due.push_back(r);
            if (it.last_base)
            begin
                fwd_word  = '0;
                rc_word   = '0;
                run_len   = 0;
                seq_total = '0;
            end
        endfunction

        task report_mismatch(string what);
            if (mismatches < 40)
                $display("[%0t] MISMATCH %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(result_t got);
            result_t want;
            if (results_due.size() == 0)
            begin
                report_mismatch($sformatf("result beat with nothing due: %h", got));
                return;
            end
            want = results_due.pop_front();
            if (got.kmer_valid !== want.kmer_valid)
                report_mismatch($sformatf("kmer_valid got %b want %b",
                                          got.kmer_valid, want.kmer_valid));
            if (got.kmer_value !== want.kmer_value)
                report_mismatch($sformatf("kmer_value got %h want %h",
                                          got.kmer_value, want.kmer_value));
            if (got.emitted_count !== want.emitted_count)
                report_mismatch($sformatf("emitted_count got %0d want %0d",
                                          got.emitted_count, want.emitted_count));
            if (got.sequence_end !== want.sequence_end)
                report_mismatch($sformatf("sequence_end got %b want %b",
                                          got.sequence_end, want.sequence_end));
        endtask

    endclass

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    logic                  item_stall;
    item_t                 item_data    = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_t               result_data;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [KMER_LEN_W-1:0] cfg_data     = '0;

    // Idle rates, in percent, of the character sender and the result receiver.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // State of the random sequence generator. A sequence can span a change of
    // the k-mer length, which is how a length change mid-sequence gets covered.
    int unsigned bases_left = 0;
    bit          noisy_seq  = 1'b0;

    kmer_scoreboard sb;

    canonical_kmer_extractor u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    // The receiver decides at each falling edge whether to stall the next beat.
    always @(negedge clk)
    begin
        result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Every result beat taken at a rising edge is checked against the oldest
    // expectation. Stall is only ever changed at the falling edge, so the
    // value seen here is the one the block saw.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result_data);
    end

    // Offers one character beat and returns at the falling edge after it was
    // taken. Valid stays high between back-to-back beats; idle cycles are only
    // inserted before the beat, each with the sender's idle rate, so valid
    // never drops while a beat is stalled.
    task automatic send_char(input logic [7:0] ch, input logic last);
        item_t it;
        it.base_char = ch;
        it.last_base = last;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item_data  <= it;
        do
            @(posedge clk);
        while (item_stall);
        sb.take_char(it);
        @(negedge clk);
    endtask

    // Waits at falling edges until every expected result beat has come back.
    task automatic wait_drained();
        while (sb.results_due.size() != 0)
            @(negedge clk);
    endtask

    // The length register is written only with no beat in flight: the sender
    // is quiet and every result has been checked. Every character produces a
    // result, so an empty expectation queue means the pipeline is empty.
    task automatic write_kmer_length(input logic [KMER_LEN_W-1:0] value);
        item_valid <= 1'b0;
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_kmer_length(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Draws the next character of a random stream of sequences. Most
    // sequences are clean runs of mixed-case bases, some long enough to push
    // the run counter into saturation; the rest carry random bytes that break
    // the run.
    task automatic send_random_char();
        logic [7:0]  ch;
        int unsigned pick;
        if (bases_left == 0)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                bases_left = $urandom_range(1, 30);
            else if (pick < 88)
                bases_left = $urandom_range(31, 80);
            else
                bases_left = $urandom_range(81, 160);
            noisy_seq = ($urandom_range(99) < 30);
        end
        if (noisy_seq && $urandom_range(99) < 12)
            ch = 8'($urandom_range(255));
        else
        begin
            case ($urandom_range(7))
                0: ch = CHAR_A_UP;
                1: ch = CHAR_C_UP;
                2: ch = CHAR_G_UP;
                3: ch = CHAR_T_UP;
                4: ch = CHAR_A_LO;
                5: ch = CHAR_C_LO;
                6: ch = CHAR_G_LO;
                default: ch = CHAR_T_LO;
            endcase
        end
        bases_left--;
        send_char(ch, bases_left == 0);
    endtask

    // Hard limit on the whole run, far above the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("canonical_kmer_extractor regression: fail");
        $finish;
    end

    initial
    begin
        logic [KMER_LEN_W-1:0] phase_len [12];
        int unsigned           drain_cycles;
        sb = new();
        phase_len = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd33, 6'd31,
                      6'd2, 6'd16, 6'd5, 6'd0, 6'd0, 6'd32};
        phase_len[9]  = 6'($urandom_range(0, 63));
        phase_len[10] = 6'($urandom_range(0, 63));

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. Light back pressure from both sides.
        send_idle_pct  = 20;
        recv_stall_pct = 30;

        // At the reset length of 31 a lone base ends a sequence with no k-mer.
        send_char(CHAR_A_UP, 1'b1);

        // k of 2: mixed case, the two extreme bytes breaking the run (the
        // total must survive the break), a palindrome where both words are
        // equal, and an invalid character carrying the last flag.
        write_kmer_length(6'd2);
        send_char(CHAR_A_UP, 1'b0);
        send_char(CHAR_C_LO, 1'b0);
        send_char(CHAR_G_UP, 1'b0);
        send_char(CHAR_T_LO, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(CHAR_G_LO, 1'b0);
        send_char(CHAR_T_UP, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(CHAR_C_UP, 1'b0);
        send_char(CHAR_A_LO, 1'b1);
        send_char(CHAR_A_UP, 1'b0);
        send_char(CHAR_T_UP, 1'b0);
        send_char("N", 1'b1);

        // k of 1: every base emits at once.
        write_kmer_length(6'd1);
        send_char(CHAR_T_LO, 1'b0);
        send_char(CHAR_A_LO, 1'b0);
        send_char(CHAR_C_UP, 1'b0);
        send_char(CHAR_G_LO, 1'b0);
        send_char(CHAR_G_UP, 1'b0);
        send_char(CHAR_C_LO, 1'b1);

        // Random part: twelve phases of 125 characters, each at its own
        // length, covering the full length, one, zero and values above the
        // maximum. The first four phases have a slow receiver, the next four
        // a slow sender, and the last four run at full rate.
        for (int p = 0; p < 12; p++)
        begin
            if (p < 4)
            begin
                send_idle_pct  = 26;
                recv_stall_pct = 48;
            end
            else if (p < 8)
            begin
                send_idle_pct  = 48;
                recv_stall_pct = 26;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            write_kmer_length(phase_len[p]);
            for (int n = 0; n < 125; n++)
                send_random_char();
        end

        // Close out: let every due result return, then keep the clock running
        // so that any stray beat can show.
        item_valid <= 1'b0;
        drain_cycles = 0;
        while (sb.results_due.size() != 0 && drain_cycles < 10000)
        begin
            @(negedge clk);
            drain_cycles++;
        end
        repeat (8) @(negedge clk);
        if (sb.results_due.size() != 0)
            sb.report_mismatch($sformatf("%0d result beats never arrived",
                                         sb.results_due.size()));

        if (sb.mismatches == 0)
            $display("canonical_kmer_extractor regression: pass");
        else
            $display("canonical_kmer_extractor regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
design/ckx_pkg.sv
design/ckx_roll.sv
design/ckx_canon.sv
design/canonical_kmer_extractor.sv
sim/canonical_kmer_extractor_tb.sv
